FILE: sv/bhre_pkg.sv
// Shared types, report constants and the microcode program of the button HID report encoder.
// No dependencies; used by bhre_slots and button_hid_report_encoder.
package bhre_pkg;

  localparam int PC_W   = 5;   // microprogram counter width
  localparam int IDX_W  = 4;   // loop index: up to 16 slots or 16 buttons
  localparam int PEND_W = 16;  // pending mask, one bit per possible button index
  localparam int BTN_W  = 12;  // width of the buttons field

  localparam logic [7:0] START_BYTE = 8'hFD;
  localparam logic [7:0] PAD_LEN    = 8'h06;
  localparam logic [7:0] KBD_DESC   = 8'h01;
  localparam logic [7:0] SCAN_BASE  = 8'h04;
  localparam logic [7:0] AXIS_POS   = 8'h7F;
  localparam logic [7:0] AXIS_NEG   = 8'h81;

  // Program entry points
  localparam logic [PC_W-1:0] PC_WAIT = 5'd0;
  localparam logic [PC_W-1:0] PC_KBD  = 5'd9;
  localparam logic [PC_W-1:0] PC_LAST = 5'd16;

  typedef enum logic [2:0] {
    OP_WAIT,       // wait for a changed button word
    OP_EMIT,       // send one fixed-source byte
    OP_RELEASE,    // walk the slots, free released keys
    OP_PLACE,      // walk the buttons, place new keys
    OP_EMIT_SLOT   // send one byte per slot
  } op_t;

  typedef enum logic [2:0] {
    SRC_START,
    SRC_PAD_LEN,
    SRC_AXIS_X,
    SRC_AXIS_Y,
    SRC_ZERO,
    SRC_PAD_BTN,
    SRC_KBD_LEN,
    SRC_DESC
  } src_t;

  typedef enum logic [1:0] {
    JMP_NONE,    // fall through to the next step
    JMP_ALWAYS,  // go to the jump target
    JMP_KBD      // go to the jump target in keyboard mode
  } cond_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic            last;
    cond_t           cond;
    logic [PC_W-1:0] jump;
  } ucode_t;

  // Commands from the sequencer to the key slot unit
  typedef struct packed {
    logic             load;
    logic             release_step;
    logic             place_step;
    logic [IDX_W-1:0] idx;
  } slot_cmd_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_WAIT, src: SRC_ZERO, last: 1'b0, cond: JMP_ALWAYS, jump: PC_WAIT};
    unique case (addr)
      5'd0:  w = '{op: OP_WAIT,      src: SRC_ZERO,    last: 1'b0, cond: JMP_KBD,    jump: PC_KBD};
      // gamepad report
      5'd1:  w = '{op: OP_EMIT,      src: SRC_START,   last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd2:  w = '{op: OP_EMIT,      src: SRC_PAD_LEN, last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd3:  w = '{op: OP_EMIT,      src: SRC_AXIS_X,  last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd4:  w = '{op: OP_EMIT,      src: SRC_AXIS_Y,  last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd5:  w = '{op: OP_EMIT,      src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd6:  w = '{op: OP_EMIT,      src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd7:  w = '{op: OP_EMIT,      src: SRC_PAD_BTN, last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd8:  w = '{op: OP_EMIT,      src: SRC_ZERO,    last: 1'b1, cond: JMP_ALWAYS, jump: PC_WAIT};
      // keyboard report
      5'd9:  w = '{op: OP_RELEASE,   src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd10: w = '{op: OP_PLACE,     src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd11: w = '{op: OP_EMIT,      src: SRC_START,   last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd12: w = '{op: OP_EMIT,      src: SRC_KBD_LEN, last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd13: w = '{op: OP_EMIT,      src: SRC_DESC,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd14: w = '{op: OP_EMIT,      src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd15: w = '{op: OP_EMIT,      src: SRC_ZERO,    last: 1'b0, cond: JMP_NONE,   jump: PC_WAIT};
      5'd16: w = '{op: OP_EMIT_SLOT, src: SRC_ZERO,    last: 1'b1, cond: JMP_ALWAYS, jump: PC_WAIT};
      default: w = '{op: OP_WAIT,    src: SRC_ZERO,    last: 1'b0, cond: JMP_ALWAYS, jump: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/bhre_slots.sv
// Key slot unit: slot registers, pending mask, release and placement steps, slot byte read.
// Depends on bhre_pkg; driven one step per cycle by the sequencer in the top level.
module bhre_slots
  import bhre_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  slot_cmd_t        cmd,
  input  logic [BTN_W-1:0] buttons,
  output logic [7:0]       slot_byte
);

  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [PEND_W-1:0]    pending;
  logic [KEY_SLOTS-1:0] used;
  logic [IDX_W-1:0]     key [KEY_SLOTS];

  logic [SW-1:0]    sel;
  logic [SW-1:0]    free_idx;
  logic             free_found;
  logic [IDX_W-1:0] sel_key;

  assign sel     = cmd.idx[SW-1:0];
  assign sel_key = key[sel];

  // lowest empty slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
      if (!used[k]) begin
        free_idx   = SW'(k);
        free_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.release_step && used[sel] && !pending[sel_key]) begin
        used[sel] <= 1'b0;
      end
      if (cmd.place_step && pending[cmd.idx] && free_found) begin
        used[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pending <= PEND_W'(buttons);
    end else if (cmd.release_step && used[sel] && pending[sel_key]) begin
      pending[sel_key] <= 1'b0;  // still held: keep the slot, drop from pending
    end
    if (cmd.place_step && pending[cmd.idx] && free_found) begin
      key[free_idx] <= cmd.idx;
    end
  end

  assign slot_byte = used[sel] ? (SCAN_BASE + 8'(sel_key)) : 8'h00;

endmodule

FILE: sv/button_hid_report_encoder.sv
// Button HID report encoder: turns a changed button word into a gamepad or keyboard report.
// Depends on bhre_pkg (types, constants, microcode ROM) and bhre_slots (key slot unit).
// Gamepad: the first byte is loaded once the word is taken. Keyboard: the first byte comes
//   after the slot release walk, then the button placement walk.
// Reports: an unchanged word is dropped; a gamepad report is 8 bytes. One microcode step runs
//   per cycle unless the one-word output register is stalled; no new word is taken until the
//   report's last byte is loaded into the output register.
// Reset: gamepad mode, every key slot empty, first button word always reports.
module button_hid_report_encoder
  import bhre_pkg::*;
#(
  parameter int KEY_SLOTS    = 6,
  parameter int BUTTON_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] buttons, [15:12] zero fill
  // report byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] report_byte
  output logic        m_axis_tlast,   // last_byte
  // configuration write: gamepad_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic             gamepad_mode;
  logic [BTN_W-1:0] prev;        // last reported word
  logic             prev_none;   // no word reported yet: forces the first report
  logic [BTN_W-1:0] bword;       // word being reported
  logic [PC_W-1:0]  pc, pc_next;
  logic [IDX_W-1:0] idx, idx_next;

  // ---------------------------------------------------------------------------
  // Microcode fetch and step control
  // ---------------------------------------------------------------------------
  ucode_t     uw;
  logic       out_free;
  logic       in_acc;
  logic       changed;
  logic       slot_end;
  logic       btn_end;
  logic       step_done;
  logic       fire;
  logic       byte_last;
  logic [7:0] byte_val;
  logic [7:0] slot_byte;
  logic [7:0] axis_x, axis_y;
  slot_cmd_t  scmd;

  assign uw       = ucode_rom(pc);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Only the wait step takes words; the output register keeps the last byte
  // meanwhile, so a new word may come in while it is still waiting.
  assign s_axis_tready = (uw.op == OP_WAIT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign changed       = prev_none || (s_axis_tdata[BTN_W-1:0] != prev);

  assign slot_end = (idx == IDX_W'(KEY_SLOTS - 1));
  assign btn_end  = (idx == IDX_W'(BUTTON_COUNT - 1));

  assign cfg_ready = 1'b1;

  // step completion and loop index
  always_comb begin
    step_done = 1'b0;
    idx_next  = idx;
    unique case (uw.op)
      OP_WAIT: begin
        step_done = in_acc && changed;
      end
      OP_EMIT: begin
        step_done = out_free;
      end
      OP_RELEASE: begin
        step_done = slot_end;
        idx_next  = idx + 1'b1;
      end
      OP_PLACE: begin
        step_done = btn_end;
        idx_next  = idx + 1'b1;
      end
      OP_EMIT_SLOT: begin
        step_done = out_free && slot_end;
        if (out_free) idx_next = idx + 1'b1;
      end
      default: begin
        step_done = 1'b0;
      end
    endcase
    if (step_done) idx_next = '0;
  end

  // next step: fall through or take the jump
  always_comb begin
    pc_next = pc;
    if (step_done) begin
      unique case (uw.cond)
        JMP_NONE:   pc_next = pc + 1'b1;
        JMP_ALWAYS: pc_next = uw.jump;
        JMP_KBD:    pc_next = gamepad_mode ? (pc + 1'b1) : uw.jump;
        default:    pc_next = PC_WAIT;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: byte select
  // ---------------------------------------------------------------------------
  // Left beats right, up beats down.
  assign axis_x = bword[5] ? AXIS_NEG : (bword[4] ? AXIS_POS : 8'h00);
  assign axis_y = bword[7] ? AXIS_NEG : (bword[6] ? AXIS_POS : 8'h00);

  always_comb begin
    fire      = 1'b0;
    byte_last = 1'b0;
    byte_val  = 8'h00;
    if ((uw.op == OP_EMIT || uw.op == OP_EMIT_SLOT) && out_free) begin
      fire = 1'b1;
    end
    if (uw.op == OP_EMIT_SLOT) begin
      byte_val  = slot_byte;
      byte_last = uw.last && slot_end;
    end else begin
      byte_last = uw.last;
      unique case (uw.src)
        SRC_START:   byte_val = START_BYTE;
        SRC_PAD_LEN: byte_val = PAD_LEN;
        SRC_AXIS_X:  byte_val = axis_x;
        SRC_AXIS_Y:  byte_val = axis_y;
        SRC_ZERO:    byte_val = 8'h00;
        SRC_PAD_BTN: byte_val = {bword[11:8], bword[3:0]};
        SRC_KBD_LEN: byte_val = 8'(3 + KEY_SLOTS);
        SRC_DESC:    byte_val = KBD_DESC;
        default:     byte_val = 8'h00;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Key slot unit
  // ---------------------------------------------------------------------------
  assign scmd.load         = in_acc && changed;
  assign scmd.release_step = (uw.op == OP_RELEASE);
  assign scmd.place_step   = (uw.op == OP_PLACE);
  assign scmd.idx          = idx;

  bhre_slots #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_slots (
    .clk       (clk),
    .rst       (rst),
    .cmd       (scmd),
    .buttons   (s_axis_tdata[BTN_W-1:0]),
    .slot_byte (slot_byte)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= PC_WAIT;
      idx           <= '0;
      gamepad_mode  <= 1'b1;
      prev_none     <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      pc  <= pc_next;
      idx <= idx_next;
      if (cfg_valid && cfg_ready) gamepad_mode <= cfg_data;
      if (in_acc && changed) prev_none <= 1'b0;
      // hold the word until taken, load the next byte when one is sent
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && changed) begin
      prev  <= s_axis_tdata[BTN_W-1:0];
      bword <= s_axis_tdata[BTN_W-1:0];
    end
    if (fire) begin
      m_axis_tdata <= byte_val;
      m_axis_tlast <= byte_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An unchanged word is dropped and the block keeps waiting.
  a_drop_same: assert property (@(posedge clk) disable iff (rst)
    in_acc && !changed |=> s_axis_tready)
    else $error("unchanged word did not leave the block waiting");

  // A changed word starts a report: no further word is taken next cycle.
  a_start_report: assert property (@(posedge clk) disable iff (rst)
    in_acc && changed |=> !s_axis_tready)
    else $error("changed word did not start a report");

  // Sending the final byte returns the sequencer to the wait step.
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    fire && byte_last |=> s_axis_tready && m_axis_tvalid && m_axis_tlast)
    else $error("final byte did not end the report");

  // The program counter stays inside the program.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_LAST)
    else $error("microprogram counter out of range");

endmodule
